// ===== design/psc_pkg.sv =====
// shared constants, register map and configuration type for the pedal sensor plausibility check
package psc_pkg;

    localparam int SensorW  = 12;
    localparam int TimeW    = 32;
    localparam int PersistW = 16;
    localparam int PctW     = 7;
    localparam int AddrW    = 4;
    localparam int DataW    = 32;

    localparam logic [SensorW-1:0]  MaxDiffReset  = 12'd409;
    localparam logic [SensorW-1:0]  LowLimReset   = 12'd5;
    localparam logic [SensorW-1:0]  HighLimReset  = 12'd3995;
    localparam logic [PersistW-1:0] PersistReset  = 16'd100;

    typedef enum logic [1:0] {
        REG_MAX_DIFF   = 2'd0,
        REG_LOW_LIMIT  = 2'd1,
        REG_HIGH_LIMIT = 2'd2,
        REG_PERSIST    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [SensorW-1:0]  max_difference;
        logic [SensorW-1:0]  low_limit;
        logic [SensorW-1:0]  high_limit;
        logic [PersistW-1:0] persist_ms;
    } cfg_t;

endpackage

// ===== design/pedal_sensor_plausibility_check.sv =====
// top level of the pedal sensor plausibility check: input register, check logic, result register
// Takes one word per clock: sensor_a, sensor_b and a millisecond timestamp. Sensor b is inverted
// (4095 - b) and the pair is implausible when the readings differ by more than max_difference or
// either reading leaves the window low_limit..high_limit. fault rises once the condition has held
// without a break for more than persist_ms (timestamps wrap modulo 2^32) and clears on the first
// plausible word. Each word also returns the mean position and its percentage 0..100. The path is
// an input register, combinational compare and fault-timer logic, and a result register; one
// word is taken every cycle as long as the result side keeps up. The user must write registers
// over the apb port while no word is in flight; the block itself does not enforce this.
module pedal_sensor_plausibility_check
    import psc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [55:0]      s_tdata,   // sensor_a[11:0], sensor_b[23:12], now_ms[55:24]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // fault[0], position_avg[12:1], position_pct[19:13], zeros
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    cfg_t cfg;

    psc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    logic               in_valid_reg;
    logic [SensorW-1:0] sensor_a_reg;
    logic [SensorW-1:0] sensor_b_reg;
    logic [TimeW-1:0]   now_reg;

    logic               out_valid_reg;
    logic               fault_out_reg;
    logic [SensorW-1:0] avg_out_reg;
    logic [PctW-1:0]    pct_out_reg;

    logic               pending_reg;
    logic               pending_next;
    logic [TimeW-1:0]   fault_start_reg;
    logic [TimeW-1:0]   fault_start_next;
    logic               fault_latched_reg;
    logic               fault_latched_next;

    logic               advance;
    logic               s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // plausibility check
    logic [SensorW-1:0] a;
    logic [SensorW-1:0] b_inv;
    logic [SensorW-1:0] gap;
    logic               bad;
    logic [TimeW-1:0]   elapsed;
    logic               expired;

    assign a       = sensor_a_reg;
    assign b_inv   = ~sensor_b_reg;
    assign gap     = (a > b_inv) ? (a - b_inv) : (b_inv - a);
    assign bad     = (gap > cfg.max_difference)
                   || (a < cfg.low_limit) || (a > cfg.high_limit)
                   || (b_inv < cfg.low_limit) || (b_inv > cfg.high_limit);
    assign elapsed = now_reg - fault_start_reg;
    assign expired = elapsed > TimeW'(cfg.persist_ms);

    always_comb begin
        pending_next       = pending_reg;
        fault_start_next   = fault_start_reg;
        fault_latched_next = fault_latched_reg;
        if (bad) begin
            if (!pending_reg) begin
                pending_next       = 1'b1;
                fault_start_next   = now_reg;
                fault_latched_next = 1'b0;
            end else if (expired) begin
                fault_latched_next = 1'b1;
            end
        end else begin
            pending_next       = 1'b0;
            fault_start_next   = '0;
            fault_latched_next = 1'b0;
        end
    end

    // mean position and percentage, x / 4095 folded as high part plus carry
    logic [SensorW:0]   sum;
    logic [SensorW-1:0] avg;
    logic [18:0]        scaled;
    logic [PctW-1:0]    scaled_hi;
    logic [SensorW:0]   fold;
    logic [PctW-1:0]    pct;

    assign sum       = {1'b0, a} + {1'b0, b_inv};
    assign avg       = sum[SensorW:1];
    assign scaled    = 19'(avg) * 19'd100;
    assign scaled_hi = scaled[18:12];
    assign fold      = (SensorW+1)'(scaled_hi) + {1'b0, scaled[11:0]};
    assign pct       = scaled_hi + PctW'(fold >= 13'd4095);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            pending_reg       <= 1'b0;
            fault_start_reg   <= '0;
            fault_latched_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg     <= 1'b1;
                pending_reg       <= pending_next;
                fault_start_reg   <= fault_start_next;
                fault_latched_reg <= fault_latched_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sensor_a_reg <= s_tdata[11:0];
            sensor_b_reg <= s_tdata[23:12];
            now_reg      <= s_tdata[55:24];
        end
        if (advance) begin
            fault_out_reg <= fault_latched_next;
            avg_out_reg   <= avg;
            pct_out_reg   <= pct;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, pct_out_reg, avg_out_reg, fault_out_reg};

endmodule

// ===== design/psc_regs.sv =====
// apb configuration registers for the pedal sensor plausibility check
module psc_regs
    import psc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output cfg_t             cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[3:2]);
    assign wr_en = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_MAX_DIFF:   cfg_next.max_difference = pwdata[SensorW-1:0];
                REG_LOW_LIMIT:  cfg_next.low_limit      = pwdata[SensorW-1:0];
                REG_HIGH_LIMIT: cfg_next.high_limit     = pwdata[SensorW-1:0];
                REG_PERSIST:    cfg_next.persist_ms     = pwdata[PersistW-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_difference <= MaxDiffReset;
            cfg_reg.low_limit      <= LowLimReset;
            cfg_reg.high_limit     <= HighLimReset;
            cfg_reg.persist_ms     <= PersistReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_MAX_DIFF:   prdata = DataW'(cfg_reg.max_difference);
            REG_LOW_LIMIT:  prdata = DataW'(cfg_reg.low_limit);
            REG_HIGH_LIMIT: prdata = DataW'(cfg_reg.high_limit);
            REG_PERSIST:    prdata = DataW'(cfg_reg.persist_ms);
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== bench/pedal_sensor_plausibility_check_tb.sv =====
// testbench for the pedal sensor plausibility check: random and directed words checked against a predictor
module pedal_sensor_plausibility_check_tb;
    import psc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [TimeW-1:0]   now_ms;
        logic [SensorW-1:0] sensor_b;
        logic [SensorW-1:0] sensor_a;
    } sensor_word_t;

    typedef struct packed {
        logic [3:0]         pad;
        logic [PctW-1:0]    position_pct;
        logic [SensorW-1:0] position_avg;
        logic               fault;
    } readout_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [55:0]      s_tdata;   // sensor_a[11:0], sensor_b[23:12], now_ms[55:24]
    logic             m_tvalid;
    logic             m_tready;
    logic [23:0]      m_tdata;   // fault[0], position_avg[12:1], position_pct[19:13], zeros
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    sensor_word_t word_queue[$];
    readout_t     readouts_due[$];
    int           mismatches = 0;
    int           send_gap_pct = 0;
    int           stall_pct = 0;
    logic         s_took = 1'b0;
    logic [31:0]  stamp_ms;

    cfg_t         live_cfg = '{MaxDiffReset, LowLimReset, HighLimReset, PersistReset};
    logic         cond_pending = 1'b0;
    logic [31:0]  cond_since_ms = '0;
    logic         fault_held = 1'b0;

    pedal_sensor_plausibility_check dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic readout_t judge_word(sensor_word_t w);
        logic [SensorW-1:0] a;
        logic [SensorW-1:0] b_inv;
        logic [SensorW-1:0] gap;
        logic [SensorW:0]   total;
        logic [31:0]        elapsed;
        logic               bad;
        int unsigned        pct;
        readout_t           r;
        a = w.sensor_a;
        b_inv = 12'd4095 - w.sensor_b;
        gap = (a > b_inv) ? a - b_inv : b_inv - a;
        bad = gap > live_cfg.max_difference
            || a < live_cfg.low_limit || a > live_cfg.high_limit
            || b_inv < live_cfg.low_limit || b_inv > live_cfg.high_limit;
        if (bad) begin
            if (!cond_pending) begin
                cond_pending = 1'b1;
                cond_since_ms = w.now_ms;
                fault_held = 1'b0;
            end else begin
                elapsed = w.now_ms - cond_since_ms;
                if (elapsed > {16'd0, live_cfg.persist_ms})
                    fault_held = 1'b1;
            end
        end else begin
            cond_pending = 1'b0;
            cond_since_ms = '0;
            fault_held = 1'b0;
        end
        total = a + b_inv;
        r = '0;
        r.fault = fault_held;
        r.position_avg = total[SensorW:1];
        pct = (r.position_avg * 100) / 4095;
        r.position_pct = pct[PctW-1:0];
        return r;
    endfunction

    // word acceptance and prediction
    always @(posedge aclk) begin
        s_took <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            readouts_due.push_back(judge_word(sensor_word_t'(s_tdata)));
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            live_cfg <= '{MaxDiffReset, LowLimReset, HighLimReset, PersistReset};
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx_t'(paddr[3:2]))
                REG_MAX_DIFF:   live_cfg.max_difference <= pwdata[SensorW-1:0];
                REG_LOW_LIMIT:  live_cfg.low_limit <= pwdata[SensorW-1:0];
                REG_HIGH_LIMIT: live_cfg.high_limit <= pwdata[SensorW-1:0];
                REG_PERSIST:    live_cfg.persist_ms <= pwdata[PersistW-1:0];
                default: ;
            endcase
        end
    end

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (word_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                s_tdata <= word_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= stall_pct);
    end

    // monitor
    always @(posedge aclk) begin
        readout_t got;
        readout_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (readouts_due.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = readouts_due.pop_front();
                if (got.fault !== want.fault) begin
                    $display("%0t: fault expected %0d actual %0d",
                             $time, want.fault, got.fault);
                    mismatches++;
                end
                if (got.position_avg !== want.position_avg) begin
                    $display("%0t: position_avg expected %0d actual %0d",
                             $time, want.position_avg, got.position_avg);
                    mismatches++;
                end
                if (got.position_pct !== want.position_pct) begin
                    $display("%0t: position_pct expected %0d actual %0d",
                             $time, want.position_pct, got.position_pct);
                    mismatches++;
                end
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, int unsigned value, int width);
        logic [31:0] junk;
        junk = $urandom;
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AddrW'(idx) << 2;
        pwdata <= ($urandom_range(1) == 1) ? ((junk << width) | value) : value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic push_word(int a, int b, logic [31:0] t);
        sensor_word_t w;
        w.sensor_a = a[SensorW-1:0];
        w.sensor_b = b[SensorW-1:0];
        w.now_ms = t;
        word_queue.push_back(w);
    endtask

    task automatic wait_drained();
        while (word_queue.size() != 0 || s_tvalid || readouts_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic pick_pair(bit want_bad, output int a, output int b);
        int lo;
        int hi;
        int md;
        int p;
        int q;
        int t;
        lo = live_cfg.low_limit;
        hi = live_cfg.high_limit;
        md = live_cfg.max_difference;
        if (!want_bad && lo <= hi) begin
            p = $urandom_range(hi, lo);
            q = p + $urandom_range(md, 0) - md / 2;
            if (q < lo) q = lo;
            if (q > hi) q = hi;
        end else begin
            p = $urandom_range(4095);
            q = $urandom_range(4095);
            case ($urandom_range(2))
                0: begin
                    if (p + md + 1 <= 4095) q = $urandom_range(4095, p + md + 1);
                    else if (p - md - 1 >= 0) q = $urandom_range(p - md - 1, 0);
                end
                1: if (lo > 0) p = $urandom_range(lo - 1, 0);
                default: if (hi < 4095) p = $urandom_range(4095, hi + 1);
            endcase
            if ($urandom_range(1) == 1) begin
                t = p;
                p = q;
                q = t;
            end
        end
        a = p;
        b = 4095 - q;
    endtask

    // runs of good or bad pairs with advancing timestamps, plus some noise words
    task automatic queue_runs(int count);
        int made;
        int run_len;
        int step_max;
        int a;
        int b;
        bit bad_run;
        made = 0;
        while (made < count) begin
            if ($urandom_range(99) < 10) begin
                push_word($urandom_range(4095), $urandom_range(4095), $urandom);
                made++;
            end else begin
                run_len = $urandom_range(12, 1);
                bad_run = $urandom_range(1);
                step_max = live_cfg.persist_ms / 6 + 2;
                for (int i = 0; i < run_len && made < count; i++) begin
                    if ($urandom_range(99) < 4) stamp_ms = $urandom;
                    else stamp_ms = stamp_ms + $urandom_range(step_max, 0);
                    pick_pair(bad_run ^ ($urandom_range(99) < 8), a, b);
                    push_word(a, b, stamp_ms);
                    made++;
                end
            end
        end
    endtask

    task automatic run_phase(int md, int lo, int hi, int pm, int count, int gap, int stall);
        write_reg(REG_MAX_DIFF, md, SensorW);
        write_reg(REG_LOW_LIMIT, lo, SensorW);
        write_reg(REG_HIGH_LIMIT, hi, SensorW);
        write_reg(REG_PERSIST, pm, PersistW);
        send_gap_pct = gap;
        stall_pct = stall;
        queue_runs(count / 2);
        wait_drained();
        queue_runs(count - count / 2);
        wait_drained();
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stamp_ms = $urandom;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: persistence boundary, gap boundary, window edges, wrap
        push_word(0, 4095, 32'd1000);
        push_word(4095, 0, 32'd1100);
        push_word(4095, 0, 32'd1101);
        push_word(4095, 4095, 32'd1102);
        push_word(2048, 2047, 32'd1103);
        push_word(1000, 2686, 32'd1104);
        push_word(1000, 2685, 32'd1105);
        push_word(5, 4090, 32'd1106);
        push_word(3995, 100, 32'd1107);
        push_word(4, 4091, 32'd2000);
        push_word(3996, 99, 32'd2050);
        push_word(3996, 99, 32'd1999);
        push_word(4095, 1, 32'd2100);
        push_word(2000, 2095, 32'hFFFF_FFC0);
        push_word(0, 0, 32'hFFFF_FFC0);
        push_word(0, 0, 32'h0000_0024);
        push_word(0, 0, 32'h0000_0025);
        push_word(1365, 2730, 32'hFFFF_FFFF);
        wait_drained();

        run_phase(409, 5, 3995, 100, 300, 0, 0);
        run_phase($urandom_range(800), $urandom_range(300), $urandom_range(4095, 3700),
                  $urandom_range(2000), 300, 61, 0);
        run_phase($urandom_range(4095), $urandom_range(300), $urandom_range(4095, 3700),
                  $urandom_range(65535), 300, 0, 61);
        run_phase($urandom_range(800), $urandom_range(300), $urandom_range(4095, 3700),
                  $urandom_range(500), 300, 30, 30);
        run_phase(0, 0, 4095, 0, 150, 30, 30);
        run_phase(4095, 4095, 0, 65535, 150, 0, 61);
        run_phase(4095, 0, 4095, 65535, 150, 61, 0);
        run_phase(0, 4095, 4095, 1, 150, 30, 30);

        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS pedal_sensor_plausibility_check");
        else
            $display("FAIL pedal_sensor_plausibility_check");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL pedal_sensor_plausibility_check");
        $finish;
    end

endmodule

// ===== sim.f =====
design/psc_pkg.sv
design/psc_regs.sv
design/pedal_sensor_plausibility_check.sv
bench/pedal_sensor_plausibility_check_tb.sv
